[rtl/boh_pkg.sv]
package boh_pkg;

  // sequencer states, one-hot
  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_RR    = 15'b000000000000100,
    S_II    = 15'b000000000001000,
    S_RI    = 15'b000000000010000,
    S_UPD   = 15'b000000000100000,
    S_BND   = 15'b000000001000000,
    S_SQI   = 15'b000000010000000,
    S_MAG   = 15'b000000100000000,
    S_DX    = 15'b000001000000000,
    S_DY    = 15'b000010000000000,
    S_DIDX  = 15'b000100000000000,
    S_RMW   = 15'b001000000000000,
    S_READ  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ITER_LIMIT = 3'd0,
    REG_EDGE_LOW   = 3'd1,
    REG_EDGE_MID   = 3'd2,
    REG_EDGE_HIGH  = 3'd3,
    REG_WIN_LEFT   = 3'd4,
    REG_WIN_TOP    = 3'd5,
    REG_PIX_SCALE  = 3'd6
  } reg_idx_e;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam int unsigned StepW     = 20;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned ScaleW    = 24;
  localparam int unsigned PixIdxW   = 16;
  localparam int unsigned ReportW   = 32;
  localparam int unsigned ScaleFrac = 16;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 120;
  localparam int unsigned PaddrW    = 5;

endpackage

[rtl/buddhabrot_orbit_histogram.sv]
// a sample item searches its orbit step by step and, if it escaped, replays those steps
// into the histogram, all on one shared 33x33 multiplier
// a read item passes through the READ and DONE states to the result; one item in flight at a time
// result register lets the next item enter while a result waits on the output
// reset clears control state, then a clearing pass zeroes the CANVAS_SIZE^2 words of the
// histogram memory (one word a cycle) before the first item is taken
module buddhabrot_orbit_histogram
  import boh_pkg::*;
#(
  parameter int unsigned CANVAS_SIZE     = 256,
  parameter int unsigned COUNT_WIDTH     = 32,
  parameter int unsigned COORD_FRAC_BITS = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // c_re, c_im, pixel_index
  input  logic                s_axis_tuser,  // kind
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // escaped, escape_steps, red, green, blue, pad
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned Depth   = CANVAS_SIZE * CANVAS_SIZE;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned PxW     = $clog2(CANVAS_SIZE);
  localparam int unsigned PixSh   = COORD_FRAC_BITS + ScaleFrac;
  localparam int unsigned WordW   = 3 * COUNT_WIDTH;
  localparam logic signed [63:0] BndLim = 64'sd1 <<< (COORD_FRAC_BITS + 1);
  localparam logic signed [63:0] MagLim = 64'sd1 <<< (2 * COORD_FRAC_BITS + 2);
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  // configuration registers
  logic [StepW-1:0]         iter_limit_q, edge_low_q, edge_mid_q, edge_high_q;
  logic signed [CoordW-1:0] win_left_q, win_top_q;
  logic [ScaleW-1:0]        pix_scale_q;
  logic                     cfg_we;
  reg_idx_e                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_limit_q <= 20'd100000;
      edge_low_q   <= 20'd10;
      edge_mid_q   <= 20'd1000;
      edge_high_q  <= 20'd20000;
      win_left_q   <= 32'shE199999A;
      win_top_q    <= 32'sh1999999A;
      pix_scale_q  <= 24'h500000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ITER_LIMIT: iter_limit_q <= pwdata[StepW-1:0];
        REG_EDGE_LOW:   edge_low_q   <= pwdata[StepW-1:0];
        REG_EDGE_MID:   edge_mid_q   <= pwdata[StepW-1:0];
        REG_EDGE_HIGH:  edge_high_q  <= pwdata[StepW-1:0];
        REG_WIN_LEFT:   win_left_q   <= $signed(pwdata);
        REG_WIN_TOP:    win_top_q    <= $signed(pwdata);
        REG_PIX_SCALE:  pix_scale_q  <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_ITER_LIMIT: prdata = 32'(iter_limit_q);
      REG_EDGE_LOW:   prdata = 32'(edge_low_q);
      REG_EDGE_MID:   prdata = 32'(edge_mid_q);
      REG_EDGE_HIGH:  prdata = 32'(edge_high_q);
      REG_WIN_LEFT:   prdata = win_left_q;
      REG_WIN_TOP:    prdata = win_top_q;
      REG_PIX_SCALE:  prdata = 32'(pix_scale_q);
      default:        prdata = '0;
    endcase
  end

  // datapath registers
  state_e                   state_q, state_d;
  logic signed [CoordW-1:0] cr_q, ci_q, re_q, im_q;
  logic [PixIdxW-1:0]       pix_q;
  logic                     kind_q, esc_q, replay_q, read_ok_q, px_in_q;
  logic [StepW-1:0]         k_q, j_q;
  logic signed [63:0]       prod_q, acc_q, nr_q, ni_q;
  logic [PxW-1:0]           px_q;
  logic [IdxW-1:0]          idx_q, clr_q;
  logic [2:0]               band_q;  // blue, green, red from bit 0 up

  // shared multiplier, result registered
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [32:0] dx, dy;

  assign dx = $signed({re_q[31], re_q}) - $signed({win_left_q[31], win_left_q});
  assign dy = $signed({win_top_q[31], win_top_q}) - $signed({im_q[31], im_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_RR:  begin mul_a = {re_q[31], re_q}; mul_b = {re_q[31], re_q}; end
      S_II:  begin mul_a = {im_q[31], im_q}; mul_b = {im_q[31], im_q}; end
      S_RI:  begin mul_a = {re_q[31], re_q}; mul_b = {im_q[31], im_q}; end
      S_BND: begin mul_a = {nr_q[31], nr_q[31:0]}; mul_b = {nr_q[31], nr_q[31:0]}; end
      S_SQI: begin mul_a = {im_q[31], im_q}; mul_b = {im_q[31], im_q}; end
      S_DX:  begin mul_a = dx; mul_b = $signed({9'd0, pix_scale_q}); end
      S_DY:  begin mul_a = dy; mul_b = $signed({9'd0, pix_scale_q}); end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
  end

  // histogram memory, {red, green, blue}
  logic [WordW-1:0] mem [Depth];
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  logic [WordW-1:0] mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  // derived step values
  logic               out_bound, mag_esc, pos_dx, pos_dy, px_ok, py_ok, accept;
  logic [63:0]        pshift;
  logic [StepW:0]     k_next, j_next;
  logic [IdxW-1:0]    idx_d;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_g, cnt_b;

  assign accept    = s_axis_tvalid & s_axis_tready;
  assign out_bound = (nr_q > BndLim) || (nr_q < -BndLim) || (ni_q > BndLim) || (ni_q < -BndLim);
  assign mag_esc   = (acc_q + prod_q) > MagLim;
  assign pos_dx    = !dx[32] && (dx != '0);
  assign pos_dy    = !dy[32] && (dy != '0);
  assign pshift    = prod_q >> PixSh;
  assign py_ok     = pshift < 64'(CANVAS_SIZE);
  assign px_ok     = pshift < 64'(CANVAS_SIZE);
  assign k_next    = {1'b0, k_q} + 1'b1;
  assign j_next    = {1'b0, j_q} + 1'b1;
  assign idx_d     = IdxW'(IdxW'(pshift[PxW-1:0]) * IdxW'(CANVAS_SIZE)) + IdxW'(px_q);
  assign {cnt_r, cnt_g, cnt_b} = rdata_q;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    mem_raddr = idx_d;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (state_q == S_RMW) begin
      mem_we    = 1'b1;
      mem_wdata = {cnt_r + COUNT_WIDTH'(band_q[2] && (cnt_r != CntMax)),
                   cnt_g + COUNT_WIDTH'(band_q[1] && (cnt_g != CntMax)),
                   cnt_b + COUNT_WIDTH'(band_q[0] && (cnt_b != CntMax))};
    end
    // keep the read word steady while the result waits
    if (state_q == S_READ || state_q == S_DONE) mem_raddr = IdxW'(pix_q);
  end

  function automatic logic [ReportW-1:0] report(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[ReportW-1:0];
  endfunction

  // result register
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  logic                 out_load;

  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (kind_q == KIND_READ) begin
        out_data_q <= {3'd0,
                       read_ok_q ? report(cnt_b) : 32'd0,
                       read_ok_q ? report(cnt_g) : 32'd0,
                       read_ok_q ? report(cnt_r) : 32'd0,
                       20'd0, 1'b0};
      end else begin
        out_data_q <= {3'd0, 96'd0, k_q, esc_q};
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == IdxW'(Depth - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == KIND_READ) state_d = S_READ;
          else if (iter_limit_q == '0)   state_d = S_DONE;
          else                           state_d = S_RR;
        end
      end
      S_RR:  state_d = S_II;
      S_II:  state_d = S_RI;
      S_RI:  state_d = S_UPD;
      S_UPD: state_d = S_BND;
      S_BND: begin
        if (replay_q)       state_d = S_DX;
        else if (out_bound) state_d = (k_q == '0) ? S_DONE : S_RR;
        else                state_d = S_SQI;
      end
      S_SQI: state_d = S_MAG;
      S_MAG: begin
        if (mag_esc)                          state_d = (k_q == '0) ? S_DONE : S_RR;
        else if (k_next < {1'b0, iter_limit_q}) state_d = S_RR;
        else                                  state_d = S_DONE;
      end
      S_DX: begin
        if (pos_dx && pos_dy)            state_d = S_DY;
        else if (j_next < {1'b0, k_q})   state_d = S_RR;
        else                             state_d = S_DONE;
      end
      S_DY: state_d = S_DIDX;
      S_DIDX: begin
        if (px_in_q && py_ok && (pshift[63:PxW] == '0) ) state_d = S_RMW;
        else if (j_next < {1'b0, k_q})   state_d = S_RR;
        else                             state_d = S_DONE;
      end
      S_RMW:  state_d = (j_next < {1'b0, k_q}) ? S_RR : S_DONE;
      S_READ: state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      replay_q <= 1'b0;
      esc_q    <= 1'b0;
      k_q      <= '0;
      j_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      // new item
      if (state_q == S_IDLE && accept) begin
        replay_q <= 1'b0;
        esc_q    <= 1'b0;
        k_q      <= '0;
        j_q      <= '0;
      end
      // escape found: start replay of the orbit
      if ((state_q == S_BND && !replay_q && out_bound) || (state_q == S_MAG && mag_esc)) begin
        esc_q    <= 1'b1;
        replay_q <= 1'b1;
      end
      if (state_q == S_MAG && !mag_esc) k_q <= k_next[StepW-1:0];
      // next replayed step
      if ((state_q == S_DX && !(pos_dx && pos_dy)) || state_q == S_RMW ||
          (state_q == S_DIDX && !(px_in_q && py_ok && (pshift[63:PxW] == '0))))
        j_q <= j_next[StepW-1:0];
    end
  end

  // payload registers of the orbit
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      kind_q    <= s_axis_tuser;
      cr_q      <= $signed(s_axis_tdata[31:0]);
      ci_q      <= $signed(s_axis_tdata[63:32]);
      re_q      <= $signed(s_axis_tdata[31:0]);
      im_q      <= $signed(s_axis_tdata[63:32]);
      pix_q     <= s_axis_tdata[79:64];
      read_ok_q <= 32'(s_axis_tdata[79:64]) < 32'(Depth);
    end
    if (state_q == S_II) acc_q <= prod_q;
    if (state_q == S_RI) acc_q <= acc_q - prod_q;
    if (state_q == S_UPD) begin
      nr_q <= (acc_q >>> COORD_FRAC_BITS) + $signed({{32{cr_q[31]}}, cr_q});
      ni_q <= (prod_q >>> (COORD_FRAC_BITS - 1)) + $signed({{32{ci_q[31]}}, ci_q});
    end
    if (state_q == S_BND) begin
      if (!replay_q && out_bound) begin
        re_q <= cr_q;
        im_q <= ci_q;
      end else begin
        re_q <= nr_q[31:0];
        im_q <= ni_q[31:0];
      end
    end
    if (state_q == S_SQI) acc_q <= prod_q;
    if (state_q == S_MAG && mag_esc) begin
      re_q <= cr_q;
      im_q <= ci_q;
    end
    // column and its range check, from the real-axis product
    if (state_q == S_DY) begin
      px_q    <= pshift[PxW-1:0];
      px_in_q <= px_ok;
    end
    if (state_q == S_DIDX) begin
      idx_q  <= idx_d;
      band_q <= {(j_q > edge_high_q) && (j_q < iter_limit_q),
                 (j_q > edge_mid_q) && (j_q < edge_high_q),
                 (j_q > edge_low_q) && (j_q < edge_mid_q)};
    end
  end

endmodule

[rtl/boh_checker.sv]
module boh_checker
  import boh_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // one item at a time: no transfer in the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // clearing pass follows reset
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  // pad bits of the result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:117] == '0)
    else $error("result pad bits set");

endmodule

bind buddhabrot_orbit_histogram boh_checker u_boh_checker (.*);

[verif/tb_buddhabrot_orbit_histogram.sv]
module tb_buddhabrot_orbit_histogram
  import boh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CANVAS    = 256;
  localparam int unsigned FRAC      = 28;
  localparam logic [2:0]  REG_SPARE = 3'd7;
  localparam longint      TIMEOUT   = 3_000_000;
  localparam int          ONE_Q     = 1 << FRAC;

  typedef struct {
    logic               kind;
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic [15:0]        pix;
  } item_t;

  typedef struct {
    logic        escaped;
    logic [19:0] steps;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
  } counts_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;  // c_re, c_im, pixel_index
  logic                s_axis_tuser;  // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;  // escaped, escape_steps, red, green, blue, pad
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  buddhabrot_orbit_histogram dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // shadow configuration and histograms
  int unsigned       lim_r, edge_lo_r, edge_mid_r, edge_hi_r;
  longint            win_left_r, win_top_r;
  longint unsigned   scale_r;
  longint unsigned   red_h[int];
  longint unsigned   green_h[int];
  longint unsigned   blue_h[int];
  int                touched_q[$];

  item_t   pend_q[$];
  counts_t counts_q[$];
  int      errs;
  longint  cyc;
  bit      in_taken;
  int      burst_left, gap_left;
  int      rx_seen, hold_cyc, rx_mode, rx_mode_left;

  // one orbit step; returns 1 when the new z leaves the radius-2 disc
  function automatic bit orbit_step(inout longint re, inout longint im,
                                    input longint cr, input longint ci);
    longint lim;
    longint nr;
    longint ni;
    lim = longint'(1) << (FRAC + 1);
    nr  = ((re * re - im * im) >>> FRAC) + cr;
    ni  = ((re * im) >>> (FRAC - 1)) + ci;
    re  = nr;
    im  = ni;
    if (nr > lim || nr < -lim || ni > lim || ni < -lim) return 1'b1;
    return nr * nr + ni * ni > (longint'(1) << (2 * FRAC + 2));
  endfunction

  function automatic void bump(inout longint unsigned cnt);
    if (cnt < 64'hFFFF_FFFF) cnt++;
  endfunction

  // map one orbit point to a pixel and count it in its band
  function automatic void deposit(longint re, longint im, int unsigned k);
    longint          dx;
    longint          dy;
    longint unsigned px;
    longint unsigned py;
    int              idx;
    dx = re - win_left_r;
    dy = win_top_r - im;
    if (dx <= 0 || dy <= 0) return;
    px = (longint'(dx) * scale_r) >> (FRAC + ScaleFrac);
    py = (longint'(dy) * scale_r) >> (FRAC + ScaleFrac);
    if (px >= CANVAS || py >= CANVAS) return;
    idx = int'(py * CANVAS + px);
    if (!red_h.exists(idx)) begin
      red_h[idx] = 0; green_h[idx] = 0; blue_h[idx] = 0;
      touched_q.push_back(idx);
    end
    if (k > edge_lo_r && k < edge_mid_r) bump(blue_h[idx]);
    if (k > edge_mid_r && k < edge_hi_r) bump(green_h[idx]);
    if (k > edge_hi_r && k < lim_r) bump(red_h[idx]);
  endfunction

  // expected result of one item; a sample item also updates the histograms
  function automatic counts_t orbit_predict(item_t it);
    counts_t     r;
    longint      cr;
    longint      ci;
    longint      re;
    longint      im;
    int unsigned k;
    bit          esc;
    r  = '{default: '0};
    if (it.kind == KIND_READ) begin
      if (red_h.exists(int'(it.pix))) begin
        r.red   = 32'(red_h[int'(it.pix)]);
        r.green = 32'(green_h[int'(it.pix)]);
        r.blue  = 32'(blue_h[int'(it.pix)]);
      end
      return r;
    end
    cr  = longint'(it.c_re);
    ci  = longint'(it.c_im);
    re  = cr;
    im  = ci;
    k   = 0;
    esc = 1'b0;
    while (k < lim_r) begin
      if (orbit_step(re, im, cr, ci)) begin
        esc = 1'b1;
        break;
      end
      k++;
    end
    r.escaped = esc;
    r.steps   = k[19:0];
    if (esc) begin
      re = cr;
      im = ci;
      for (int unsigned j = 0; j < k; j++) begin
        void'(orbit_step(re, im, cr, ci));
        deposit(re, im, j);
      end
    end
    return r;
  endfunction

  // clock and cycle limit
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > TIMEOUT) begin
      $display("buddhabrot_orbit_histogram test failed");
      $finish;
    end
  end

  // input transfers: predict at acceptance
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      counts_q.push_back(orbit_predict(pend_q[0]));
      in_taken = 1'b1;
    end
  end

  // driver: bursts with random gaps, an offered item held until its transfer
  always @(negedge clk_i) begin
    bit waiting;
    waiting = s_axis_tvalid && !in_taken;
    if (rst_ni && !waiting) begin
      if (in_taken) begin
        void'(pend_q.pop_front());
        in_taken = 1'b0;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pend_q[0].pix, pend_q[0].c_im, pend_q[0].c_re};
        s_axis_tuser  <= pend_q[0].kind;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      if (hold_cyc > 0) begin
        hold_cyc--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    counts_t got;
    counts_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.escaped = m_axis_tdata[0];
      got.steps   = m_axis_tdata[20:1];
      got.red     = m_axis_tdata[52:21];
      got.green   = m_axis_tdata[84:53];
      got.blue    = m_axis_tdata[116:85];
      rx_seen++;
      if (rx_seen == 30) hold_cyc = 400;
      if (counts_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        errs++;
      end else begin
        want = counts_q.pop_front();
        if (got.escaped !== want.escaped) begin
          $error("escaped: expected %0d, got %0d", want.escaped, got.escaped);
          errs++;
        end
        if (got.steps !== want.steps) begin
          $error("escape_steps: expected %0d, got %0d", want.steps, got.steps);
          errs++;
        end
        if (got.red !== want.red) begin
          $error("red_count: expected %0d, got %0d", want.red, got.red);
          errs++;
        end
        if (got.green !== want.green) begin
          $error("green_count: expected %0d, got %0d", want.green, got.green);
          errs++;
        end
        if (got.blue !== want.blue) begin
          $error("blue_count: expected %0d, got %0d", want.blue, got.blue);
          errs++;
        end
      end
    end
  end

  // register write through the config port, mirrored in the shadow copy
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ITER_LIMIT: lim_r      = 32'(val[19:0]);
      REG_EDGE_LOW:   edge_lo_r  = 32'(val[19:0]);
      REG_EDGE_MID:   edge_mid_r = 32'(val[19:0]);
      REG_EDGE_HIGH:  edge_hi_r  = 32'(val[19:0]);
      REG_WIN_LEFT:   win_left_r = longint'(signed'(val));
      REG_WIN_TOP:    win_top_r  = longint'(signed'(val));
      REG_PIX_SCALE:  scale_r    = 64'(val[23:0]);
      default: ;
    endcase
  endtask

  task automatic push_sample(int re, int im);
    pend_q.push_back('{KIND_SAMPLE, re, im, 16'h0});
  endtask

  task automatic push_read(int unsigned idx);
    pend_q.push_back('{KIND_READ, $urandom, $urandom, idx[15:0]});
  endtask

  task automatic read_touched();
    if (touched_q.size() > 0)
      push_read(touched_q[$urandom_range(0, touched_q.size() - 1)]);
    else
      push_read($urandom_range(0, 65535));
  endtask

  // sender waits until every item is through and every result is back
  task automatic drain();
    while (pend_q.size() > 0 || counts_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    lim_r      = 100000;
    edge_lo_r  = 10;
    edge_mid_r = 1000;
    edge_hi_r  = 20000;
    win_left_r = -510027366;
    win_top_r  = 429496730;
    scale_r    = 5242880;
    errs = 0; cyc = 0; in_taken = 1'b0;
    burst_left = 0; gap_left = 0;
    rx_seen = 0; hold_cyc = 0; rx_mode = 0; rx_mode_left = 0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero step limit, and a write to an unused address
    reg_write(REG_ITER_LIMIT, 32'd0);
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    push_sample(0, 0);
    push_read(0);
    push_read(65535);
    drain();

    // largest step limit with points that escape at once
    reg_write(REG_ITER_LIMIT, 32'hFFFFF);
    reg_write(REG_EDGE_LOW, 32'd0);
    reg_write(REG_EDGE_MID, 32'd0);
    reg_write(REG_EDGE_HIGH, 32'd0);
    push_sample(32'h7FFF_FFFF, 0);
    push_sample(32'h8000_0000, 32'h8000_0000);
    push_sample(0, 32'h7FFF_FFFF);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_sample(3 * ONE_Q, 0);
    push_sample(ONE_Q, ONE_Q);
    drain();

    // main setting: small limit, window of -2..2 on both axes
    reg_write(REG_ITER_LIMIT, 32'd200);
    reg_write(REG_EDGE_LOW, 32'd2);
    reg_write(REG_EDGE_MID, 32'd20);
    reg_write(REG_EDGE_HIGH, 32'd60);
    reg_write(REG_WIN_LEFT, -2 * ONE_Q);
    reg_write(REG_WIN_TOP, 2 * ONE_Q);
    reg_write(REG_PIX_SCALE, 32'd64 << 16);
    push_sample(0, 0);
    push_sample(-2 * ONE_Q, 0);
    push_sample(107374182, -80530637);
    push_sample(80530637, 0);
    push_sample(-201326592, 26843546);
    push_sample(-201326592, 30000000);
    drain();
    repeat (4) read_touched();
    for (int i = 0; i < 70; i++) begin
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)
        push_sample(-590558003 + int'($urandom_range(0, 805306368)),
                    -402653184 + int'($urandom_range(0, 805306368)));
      else if (sel < 75)
        read_touched();
      else if (sel < 85)
        push_read($urandom_range(0, 65535));
      else
        push_sample($urandom, $urandom);
    end
    drain();
    repeat (6) read_touched();
    drain();

    // zero scale with the widest window: all of the quadrant lands on pixel 0
    reg_write(REG_ITER_LIMIT, 32'd50);
    reg_write(REG_PIX_SCALE, 32'd0);
    reg_write(REG_WIN_LEFT, 32'h8000_0000);
    reg_write(REG_WIN_TOP, 32'h7FFF_FFFF);
    reg_write(REG_EDGE_HIGH, 32'd3);
    push_sample(80530637, 107374182);
    push_sample(-201326592, 30000000);
    push_read(0);
    drain();

    // largest scale and edges at their tops
    reg_write(REG_PIX_SCALE, 32'hFF_FFFF);
    reg_write(REG_EDGE_LOW, 32'hFFFFF);
    reg_write(REG_EDGE_MID, 32'hFFFFF);
    reg_write(REG_EDGE_HIGH, 32'hFFFFF);
    push_sample(80530637, 107374182);
    push_sample(-201326592, 30000000);
    push_read(0);
    push_read(1);
    drain();

    repeat (50) @(posedge clk_i);
    if (errs == 0) begin
      $display("buddhabrot_orbit_histogram test passed");
    end else begin
      $display("buddhabrot_orbit_histogram test failed");
    end
    $finish;
  end

endmodule
